FILE: hdl/tma_pkg.sv
// Shared constants and types for the trailing moving average block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package tma_pkg;

  localparam int MaxWindowDef  = 32;
  localparam int SampleBitsDef = 16;
  localparam int CfgBits       = 6;
  localparam logic [CfgBits-1:0] WindowReset = CfgBits'(4);

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StSum   = 5'b00010,
    StDiv   = 5'b00100,
    StWrite = 5'b01000,
    StSpare = 5'b10000
  } tma_state_e;

endpackage

FILE: hdl/tma_if.sv
// Valid/ready channel interfaces: sample input, result output, window config.
// Depends on tma_pkg for default widths.
`timescale 1ns / 1ps

interface tma_in_if #(
  parameter int SampleBits = tma_pkg::SampleBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface tma_out_if #(
  parameter int SampleBits = tma_pkg::SampleBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] average;
  logic                         is_passthrough;

  modport source (output valid, output average, output is_passthrough, input ready);
  modport sink   (input valid, input average, input is_passthrough, output ready);
endinterface

interface tma_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tma_pkg::CfgBits-1:0]  window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

FILE: hdl/tma_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tma_ram #(
  parameter int Width = 16,
  parameter int Depth = 32,
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic [Width-1:0]    wdata_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tma_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
`timescale 1ns / 1ps

module tma_div #(
  parameter int DividendBits = 21,
  parameter int DivisorBits  = 6,
  localparam int CntBits = $clog2(DividendBits + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DividendBits-1:0] dividend_i,
  input  logic [DivisorBits-1:0]  divisor_i,
  output logic                    done_o,
  output logic [DividendBits-1:0] quotient_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic [DivisorBits-1:0]  rem_q, rem_d;
  logic [DivisorBits-1:0]  dsr_q, dsr_d;
  logic [DividendBits-1:0] quo_q, quo_d;
  logic [DivisorBits:0]    trial;
  logic [DivisorBits:0]    diff;
  logic                    ge;

  // shift in next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[DividendBits-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivisorBits-1:0] : trial[DivisorBits-1:0];
      quo_d = {quo_q[DividendBits-2:0], ge};
      cnt_d = cnt_q + CntBits'(1);
      if (cnt_q == CntBits'(DividendBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/trailing_moving_average.sv
// Top level of the trailing moving average: sequencer, sample history, output register.
// Depends on tma_pkg, tma_if, tma_ram and tma_div.
`timescale 1ns / 1ps

// Usage:
//   in_i   : sample words (signed Q1.15 sample, last_sample marks block end).
//   out_o  : one result word per sample (average, is_passthrough).
//   cfg_i  : window_length, always ready; write only while the block is idle.
// While fewer than window_length samples of the current block have been seen,
// the sample is passed through. After that the result is the mean of the
// preceding window_length samples, truncated toward zero.
// A passthrough word goes from acceptance through the write step into the output
// register. A mean passes the sum step (one RAM read per cycle, then the last
// read drains and the divider starts), the serial divider and the write step
// before it reaches the output register; the next sample is taken only after
// the write step has returned the sequencer to idle.
// One sample is in flight at a time; in_i.ready is high only when idle.
// The output register frees the input side: a new sample is accepted while a
// result waits; if the receiver stalls, the next result holds in the write
// step until the register drains. Reset empties the history (by clearing the
// fill count and write pointer; no clearing pass) and sets window_length to 4.
module trailing_moving_average #(
  parameter int MaxWindow  = tma_pkg::MaxWindowDef,
  parameter int SampleBits = tma_pkg::SampleBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tma_in_if.sink    in_i,
  tma_out_if.source out_o,
  tma_cfg_if.sink   cfg_i
);

  import tma_pkg::*;

  localparam int WinBits  = $clog2(MaxWindow + 1);
  localparam int AddrBits = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int SumBits  = SampleBits + $clog2(MaxWindow);

  tma_state_e state_q, state_d;

  logic [CfgBits-1:0]        win_cfg_q;
  logic [31:0]               win_wide;
  logic [WinBits-1:0]        win_eff;
  logic [WinBits-1:0]        seen_q, seen_d;
  logic [AddrBits-1:0]       wp_q, wp_d;
  logic [AddrBits-1:0]       rd_addr_q, rd_addr_d;
  logic [WinBits-1:0]        issued_q, issued_d;
  logic                      pend_q, pend_d;
  logic signed [SumBits-1:0] acc_q, acc_d;
  logic signed [SampleBits-1:0] smp_q, smp_d;
  logic                      last_q, last_d;
  logic                      neg_q, neg_d;
  logic signed [SampleBits-1:0] res_q, res_d;
  logic                      pass_q, pass_d;
  logic                      ovalid_q, ovalid_d;
  logic signed [SampleBits-1:0] oavg_q, oavg_d;
  logic                      opass_q, opass_d;

  logic                      out_free;
  logic                      issue;
  logic                      ram_we, ram_re;
  logic [AddrBits-1:0]       ram_addr;
  logic [SampleBits-1:0]     ram_rdata;
  logic                      div_start, div_done;
  logic [SumBits-1:0]        div_dividend;
  logic [SumBits-1:0]        div_quot;
  logic [SumBits-1:0]        quot_signed;

  // window length: zero means one, clipped to the history depth
  always_comb begin
    if (win_cfg_q == '0) begin
      win_wide = 32'd1;
    end else if (32'(win_cfg_q) > 32'(MaxWindow)) begin
      win_wide = 32'(MaxWindow);
    end else begin
      win_wide = 32'(win_cfg_q);
    end
  end
  assign win_eff = win_wide[WinBits-1:0];

  assign out_free = !ovalid_q || out_o.ready;
  assign issue    = (state_q == StSum) && (issued_q != win_eff);

  assign div_dividend = acc_q[SumBits-1] ? SumBits'(-acc_q) : SumBits'(acc_q);
  assign quot_signed  = neg_q ? -div_quot : div_quot;

  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    wp_d      = wp_q;
    rd_addr_d = rd_addr_q;
    issued_d  = issued_q;
    pend_d    = 1'b0;
    acc_d     = acc_q;
    smp_d     = smp_q;
    last_d    = last_q;
    neg_d     = neg_q;
    res_d     = res_q;
    pass_d    = pass_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    oavg_d    = oavg_q;
    opass_d   = opass_q;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = rd_addr_q;

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          smp_d  = in_i.sample;
          last_d = in_i.last_sample;
          if (seen_q < win_eff) begin
            res_d   = in_i.sample;
            pass_d  = 1'b1;
            state_d = StWrite;
          end else begin
            pass_d    = 1'b0;
            acc_d     = '0;
            issued_d  = '0;
            rd_addr_d = (wp_q == '0) ? AddrBits'(MaxWindow - 1) : wp_q - AddrBits'(1);
            state_d   = StSum;
          end
        end
      end
      StSum: begin
        // one read issued per cycle, data summed in the cycle after the read
        if (issue) begin
          ram_re    = 1'b1;
          pend_d    = 1'b1;
          issued_d  = issued_q + WinBits'(1);
          rd_addr_d = (rd_addr_q == '0) ? AddrBits'(MaxWindow - 1)
                                        : rd_addr_q - AddrBits'(1);
        end
        if (pend_q) begin
          acc_d = acc_q + SumBits'($signed(ram_rdata));
        end
        if (!issue && !pend_q) begin
          div_start = 1'b1;
          neg_d     = acc_q[SumBits-1];
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          res_d   = quot_signed[SampleBits-1:0];
          state_d = StWrite;
        end
      end
      StWrite: begin
        ram_addr = wp_q;
        if (out_free) begin
          ram_we   = 1'b1;
          ovalid_d = 1'b1;
          oavg_d   = res_q;
          opass_d  = pass_q;
          if (last_q) begin
            wp_d   = '0;
            seen_d = '0;
          end else begin
            wp_d = (wp_q == AddrBits'(MaxWindow - 1)) ? '0 : wp_q + AddrBits'(1);
            if (seen_q != WinBits'(MaxWindow)) begin
              seen_d = seen_q + WinBits'(1);
            end
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      win_cfg_q <= WindowReset;
      seen_q    <= '0;
      wp_q      <= '0;
      issued_q  <= '0;
      pend_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      seen_q   <= seen_d;
      wp_q     <= wp_d;
      issued_q <= issued_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
      if (cfg_i.valid) begin
        win_cfg_q <= cfg_i.window_length;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    acc_q     <= acc_d;
    smp_q     <= smp_d;
    last_q    <= last_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
    pass_q    <= pass_d;
    oavg_q    <= oavg_d;
    opass_q   <= opass_d;
  end

  tma_ram #(
    .Width (SampleBits),
    .Depth (MaxWindow)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (smp_q),
    .rdata_o (ram_rdata)
  );

  tma_div #(
    .DividendBits (SumBits),
    .DivisorBits  (WinBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (win_eff),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_i.ready           = (state_q == StIdle);
  assign cfg_i.ready          = 1'b1;
  assign out_o.valid          = ovalid_q;
  assign out_o.average        = oavg_q;
  assign out_o.is_passthrough = opass_q;

endmodule

FILE: verif/trailing_moving_average_test.sv
// Self-checking bench for trailing_moving_average: drives sample words, predicts
// each average and passthrough flag, checks every result word in order.
// Depends on tma_pkg, tma_if and the RTL of the block.
`timescale 1ns / 1ps

module trailing_moving_average_test;
  import tma_pkg::*;

  localparam int MaxWin      = MaxWindowDef;
  localparam int SBits       = SampleBitsDef;
  localparam int PtrBits     = $clog2(MaxWin);
  localparam int TotalWords  = 550;
  localparam int QuietFrom   = 480;
  localparam int DrainCycles = 80;

  typedef logic signed [SBits-1:0] sample_t;
  typedef struct { sample_t sample; logic last; } sample_word_t;
  typedef struct { sample_t average; logic passthrough; } avg_word_t;

  localparam sample_t SampleMax = {1'b0, {(SBits-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SBits-1){1'b0}}};

  logic clk;
  logic rst_n;

  tma_in_if  #(.SampleBits(SBits)) in_ch ();
  tma_out_if #(.SampleBits(SBits)) out_ch ();
  tma_cfg_if                       cfg_ch ();

  trailing_moving_average #(
    .MaxWindow (MaxWin),
    .SampleBits(SBits)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  sample_word_t pending_q[$];
  avg_word_t    averages_due_q[$];

  // Mirror of the block's history and window setting
  sample_t              hist_mem [MaxWin];
  int unsigned          fill_cnt;
  logic [PtrBits-1:0]   wr_ptr;
  logic [CfgBits-1:0]   win_reg;

  bit quiet;
  int fail_cnt;
  int words_queued;
  int means_seen;
  int pass_seen;
  int blocks_seen;
  int windows_set;
  int blk_left;
  int gap_left;
  int stall_left;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned eff_window();
    if (win_reg == 0) return 1;
    if (win_reg > MaxWin) return MaxWin;
    return win_reg;
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < MaxWin; i++) hist_mem[i] = '0;
    fill_cnt = 0;
    wr_ptr   = '0;
  endfunction

  // One sample in, one expected word out; history advances as in the block
  function automatic avg_word_t advance_average(sample_t x, logic last);
    avg_word_t   res;
    int unsigned w;
    longint      acc;
    w   = eff_window();
    acc = 0;
    if (fill_cnt < w) begin
      res.average     = x;
      res.passthrough = 1'b1;
    end else begin
      for (int k = 1; k <= w; k++) acc += hist_mem[PtrBits'(wr_ptr - k)];
      res.average     = sample_t'(acc / longint'(w));
      res.passthrough = 1'b0;
    end
    hist_mem[wr_ptr] = x;
    wr_ptr++;
    if (fill_cnt < MaxWin) fill_cnt++;
    if (last) begin
      clear_history();
      blocks_seen++;
    end
    return res;
  endfunction

  // Sample driver
  always @(posedge clk) begin
    sample_word_t nxt;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        averages_due_q.push_back(advance_average(in_ch.sample, in_ch.last_sample));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 11);
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.sample      <= nxt.sample;
          in_ch.last_sample <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    avg_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (averages_due_q.size() == 0) begin
          $error("result word with none due: average %0d, is_passthrough %0b",
                 out_ch.average, out_ch.is_passthrough);
          fail_cnt++;
        end else begin
          want = averages_due_q.pop_front();
          if (out_ch.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, out_ch.average);
            fail_cnt++;
          end
          if (out_ch.is_passthrough !== want.passthrough) begin
            $error("is_passthrough: expected %0b, got %0b",
                   want.passthrough, out_ch.is_passthrough);
            fail_cnt++;
          end
          if (want.passthrough) pass_seen++;
          else means_seen++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_window(input logic [CfgBits-1:0] len);
    @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.window_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    win_reg = len;
    windows_set++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_ch.valid || averages_due_q.size() != 0);
  endtask

  task automatic queue_word(input sample_t s, input logic last);
    sample_word_t wd;
    wd.sample = s;
    wd.last   = last;
    pending_q.push_back(wd);
    words_queued++;
  endtask

  function automatic sample_t pick_sample();
    int tmp;
    case ($urandom_range(0, 9))
      0: return SampleMax;
      1: return SampleMin;
      2: begin
        tmp = $urandom_range(0, 16);
        return sample_t'(tmp - 8);
      end
      3: return SampleMax - sample_t'($urandom_range(0, 3));
      4: return SampleMin + sample_t'($urandom_range(0, 3));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Block lengths mostly outrun the window so means dominate
  function automatic logic pick_last();
    if (blk_left == 0) begin
      if ($urandom_range(0, 4) == 0) blk_left = $urandom_range(1, 6);
      else blk_left = eff_window() + $urandom_range(1, 40);
    end
    blk_left--;
    return blk_left == 0;
  endfunction

  function automatic logic [CfgBits-1:0] pick_window();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CfgBits'(MaxWin);
      2: return '1;
      3: return CfgBits'(MaxWin + 1);
      4: return CfgBits'($urandom_range(MaxWin + 2, (1 << CfgBits) - 1));
      5: return CfgBits'($urandom_range(9, MaxWin - 1));
      default: return CfgBits'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    int n;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.sample         = '0;
    in_ch.last_sample    = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.window_length = WindowReset;
    quiet                = 1'b0;
    fail_cnt             = 0;
    words_queued         = 0;
    means_seen           = 0;
    pass_seen            = 0;
    blocks_seen          = 0;
    windows_set          = 0;
    blk_left             = 0;
    gap_left             = 0;
    stall_left           = 0;
    win_reg              = WindowReset;
    clear_history();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window: full-scale runs both ways, then a block end
    for (int i = 0; i < 5; i++) queue_word(SampleMax, 1'b0);
    for (int i = 0; i < 5; i++) queue_word(SampleMin, 1'b0);
    queue_word(sample_t'(0), 1'b0);
    queue_word(sample_t'(-1), 1'b1);
    wait_idle();

    // Zero length acts as one
    write_window('0);
    queue_word(sample_t'(5), 1'b0);
    queue_word(sample_t'(-3), 1'b0);
    queue_word(sample_t'(-2), 1'b0);
    wait_idle();

    // Length change inside a block; a sum that does not divide evenly checks truncation
    write_window(CfgBits'(3));
    queue_word(sample_t'(7), 1'b0);
    queue_word(sample_t'(1), 1'b1);
    wait_idle();

    // Above the maximum saturates; block left open for the random part
    write_window(CfgBits'(MaxWin + 1));
    queue_word(sample_t'(-7), 1'b0);
    queue_word(SampleMax, 1'b0);
    queue_word(SampleMin, 1'b0);
    wait_idle();

    while (words_queued < TotalWords) begin
      if (words_queued >= QuietFrom) quiet = 1'b1;
      write_window(pick_window());
      n = $urandom_range(8, 60);
      for (int i = 0; i < n && words_queued < TotalWords; i++) begin
        queue_word(pick_sample(), pick_last());
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk);
    if (averages_due_q.size() != 0) begin
      $error("%0d result words never arrived", averages_due_q.size());
      fail_cnt++;
    end
    $display("Ran %0d sample words in %0d closed blocks under %0d window writes,",
             words_queued, blocks_seen, windows_set);
    $display("giving %0d passthrough words and %0d trailing means.", pass_seen, means_seen);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Slowest run is well under half a millisecond
  initial begin
    #3_000_000;
    $display("Run timed out");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hdl/tma_pkg.sv
hdl/tma_if.sv
hdl/tma_ram.sv
hdl/tma_div.sv
hdl/trailing_moving_average.sv
verif/trailing_moving_average_test.sv
